FILE: src/ira_pkg.sv
`default_nettype none

package ira_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ELEM_W        = 18;
    localparam int ANGLE_W       = 10;
    localparam int DEG_W         = 9;

    localparam logic OP_ROTATE = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    localparam logic [1:0] AXIS_X     = 2'd0;
    localparam logic [1:0] AXIS_Y     = 2'd1;
    localparam logic [1:0] AXIS_Z     = 2'd2;
    localparam logic [1:0] AXIS_FINAL = 2'd3;

    localparam logic [63:0] Q30_ONE         = 64'd1 << 30;
    localparam logic [63:0] PI_Q30          = 64'd3373259426;
    localparam logic [63:0] DEG_HALF_TURN   = 64'd180;
    localparam logic [63:0] SERIES_DEN [1:8] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

    typedef logic [31:0] sin_tab_t [0:90];

    typedef struct packed {
        logic       reset_state;
        logic       capture;
        logic       init_t;
        logic       load_g;
        logic [1:0] axis;
        logic       mac_issue;
        logic       mac_first;
        logic       mac_last;
        logic       mac_final;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] k;
        logic       commit_t;
        logic       commit_m;
        logic       out_load;
        logic [1:0] out_row;
    } cmd_t;

    typedef struct packed {
        logic [2:0] nonzero;
        logic       out_free;
    } stat_t;

    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // Sine of 0..90 degrees, evaluated at elaboration with a Horner series in Q30.
    function automatic sin_tab_t build_sin_tab(input int fb);
        sin_tab_t    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        int          sh;
        sh = 30 - fb;
        for (int k = 0; k <= 90; k++)
        begin
            if (k == 90)
            begin
                t = Q30_ONE;
            end
            else
            begin
                x  = (64'(k) * PI_Q30 + 64'd90) / DEG_HALF_TURN;
                x2 = mul_q30(x, x);
                t  = Q30_ONE;
                for (int m = 8; m >= 1; m--)
                begin
                    t = Q30_ONE - mul_q30(x2, t) / SERIES_DEN[m];
                end
                t = mul_q30(x, t);
            end
            if (sh > 0)
            begin
                t = (t + (64'd1 << (sh - 1))) >> sh;
            end
            tab[k] = t[31:0];
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

FILE: src/ira_ctrl.sv
`default_nettype none

module ira_ctrl
    import ira_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  in_op,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_NEXT   = 3'd1;
    localparam logic [2:0] S_LOADG  = 3'd2;
    localparam logic [2:0] S_MAC    = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [1:0] i_reg, i_next;
    logic [1:0] j_reg, j_next;
    logic [1:0] k_reg, k_next;
    logic       skip_reg, skip_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= AXIS_X;
            i_reg     <= 2'd0;
            j_reg     <= 2'd0;
            k_reg     <= 2'd0;
            skip_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            skip_reg  <= skip_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        skip_next  = skip_reg;
        cmd        = '0;
        cmd.axis      = axis_reg;
        cmd.row       = i_reg;
        cmd.col       = j_reg;
        cmd.k         = k_reg;
        cmd.mac_final = (axis_reg == AXIS_FINAL);
        cmd.out_row   = i_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == OP_RESET)
                    begin
                        cmd.reset_state = 1'b1;
                        skip_next       = 1'b1;
                    end
                    else if (skip_reg)
                    begin
                        skip_next  = 1'b0;
                        i_next     = 2'd0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        cmd.init_t  = 1'b1;
                        axis_next   = AXIS_X;
                        state_next  = S_NEXT;
                    end
                end
            end
            S_NEXT:
            begin
                i_next = 2'd0;
                j_next = 2'd0;
                k_next = 2'd0;
                if (axis_reg == AXIS_FINAL)
                begin
                    state_next = S_MAC;
                end
                else if (stat.nonzero[axis_reg])
                begin
                    state_next = S_LOADG;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            S_LOADG:
            begin
                cmd.load_g = 1'b1;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                cmd.mac_issue = 1'b1;
                cmd.mac_first = (k_reg == 2'd0);
                cmd.mac_last  = (k_reg == 2'd2);
                if (k_reg != 2'd2)
                begin
                    k_next = k_reg + 2'd1;
                end
                else
                begin
                    k_next = 2'd0;
                    if (j_reg != 2'd2)
                    begin
                        j_next = j_reg + 2'd1;
                    end
                    else
                    begin
                        j_next = 2'd0;
                        if (i_reg != 2'd2)
                        begin
                            i_next = i_reg + 2'd1;
                        end
                        else
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (axis_reg == AXIS_FINAL)
                begin
                    cmd.commit_m = 1'b1;
                    i_next       = 2'd0;
                    state_next   = S_EMIT;
                end
                else
                begin
                    cmd.commit_t = 1'b1;
                    axis_next    = axis_reg + 2'd1;
                    state_next   = S_NEXT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    i_next       = i_reg + 2'd1;
                    if (i_reg == 2'd3)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/ira_datapath.sv
`default_nettype none

module ira_datapath
    import ira_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cmd_t                       cmd,
    output stat_t                           stat,
    input  wire logic signed [ANGLE_W-1:0]  angle_x,
    input  wire logic signed [ANGLE_W-1:0]  angle_y,
    input  wire logic signed [ANGLE_W-1:0]  angle_z,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      out_row,
    output logic signed [ELEM_W-1:0]        out_e0,
    output logic signed [ELEM_W-1:0]        out_e1,
    output logic signed [ELEM_W-1:0]        out_e2,
    output logic signed [ELEM_W-1:0]        out_e3,
    output logic                            out_last
);

    localparam int SW  = FRAC_BITS + 2;
    localparam int AW  = (SW > ELEM_W) ? SW : ELEM_W;
    localparam int PW  = AW + SW;
    localparam int ACW = PW + 2;
    localparam sin_tab_t SIN_TAB = build_sin_tab(FRAC_BITS);

    localparam logic signed [SW-1:0] ONE_T = SW'(1) <<< FRAC_BITS;
    localparam logic signed [ELEM_W-1:0] ONE_M =
        (FRAC_BITS >= ELEM_W - 1) ? ELEM_W'(131071) : ELEM_W'(1) <<< FRAC_BITS;
    localparam logic signed [ACW-1:0] EMAX = ACW'(131071);
    localparam logic signed [ACW-1:0] EMIN = -ACW'(131072);
    localparam logic signed [ACW-1:0] HALF = ACW'(1) <<< (FRAC_BITS - 1);

    logic signed [ELEM_W-1:0]  m_reg [0:8];
    logic signed [SW-1:0]      t_reg [0:8];
    logic signed [SW-1:0]      g_reg [0:8];
    logic signed [AW-1:0]      n_reg [0:8];
    logic signed [ANGLE_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [ANGLE_W-1:0] ax_reg, ay_reg, az_reg;
    logic [DEG_W-1:0]          dx_reg, dy_reg, dz_reg;

    logic signed [PW-1:0]  prod_reg;
    logic                  pv_reg, pfirst_reg, plast_reg, pfinal_reg;
    logic [3:0]            pidx_reg;
    logic signed [ACW-1:0] acc_reg;

    logic                  out_valid_reg;
    logic [1:0]            out_row_reg;
    logic signed [ELEM_W-1:0] oe0_reg, oe1_reg, oe2_reg;

    // Difference of two angles reduced into 0..359.
    function automatic logic [DEG_W-1:0] reduce360(input logic signed [ANGLE_W-1:0] a,
                                                   input logic signed [ANGLE_W-1:0] p);
        logic [11:0] r;
        r = 12'(12'(signed'(a)) - 12'(signed'(p)) + 12'd1080);
        for (int s = 0; s < 5; s++)
        begin
            if (r >= 12'd360)
            begin
                r = r - 12'd360;
            end
        end
        return r[DEG_W-1:0];
    endfunction

    function automatic logic signed [SW-1:0] sin_deg(input logic [DEG_W-1:0] d);
        logic [DEG_W-1:0]     idx;
        logic                 neg;
        logic signed [SW-1:0] v;
        neg = 1'b0;
        if (d <= DEG_W'(90))
        begin
            idx = d;
        end
        else if (d <= DEG_W'(180))
        begin
            idx = DEG_W'(180) - d;
        end
        else if (d <= DEG_W'(270))
        begin
            idx = d - DEG_W'(180);
            neg = 1'b1;
        end
        else
        begin
            idx = DEG_W'(360) - d;
            neg = 1'b1;
        end
        v = SIN_TAB[idx[6:0]][SW-1:0];
        return neg ? -v : v;
    endfunction

    function automatic logic [DEG_W-1:0] quarter_on(input logic [DEG_W-1:0] d);
        logic [DEG_W-1:0] e;
        e = d + DEG_W'(90);
        return (e >= DEG_W'(360)) ? e - DEG_W'(360) : e;
    endfunction

    logic [DEG_W-1:0]     d_sel;
    logic signed [SW-1:0] s_val, c_val;

    always_comb
    begin
        case (cmd.axis)
            AXIS_X:  d_sel = dx_reg;
            AXIS_Y:  d_sel = dy_reg;
            default: d_sel = dz_reg;
        endcase
        s_val = sin_deg(d_sel);
        c_val = sin_deg(quarter_on(d_sel));
    end

    logic [3:0]            a_idx, b_idx, e_idx;
    logic signed [AW-1:0]  a_op;
    logic signed [SW-1:0]  b_op;
    logic signed [ACW-1:0] sum, rnd;
    logic signed [AW-1:0]  res;

    always_comb
    begin
        a_idx = 4'({cmd.row, 1'b0}) + 4'(cmd.row) + 4'(cmd.k);
        b_idx = 4'({cmd.k, 1'b0}) + 4'(cmd.k) + 4'(cmd.col);
        e_idx = 4'({cmd.row, 1'b0}) + 4'(cmd.row) + 4'(cmd.col);
        a_op  = cmd.mac_final ? AW'(m_reg[a_idx]) : AW'(g_reg[a_idx]);
        b_op  = t_reg[b_idx];
        sum   = (pfirst_reg ? '0 : acc_reg) + ACW'(prod_reg);
        rnd   = (sum + HALF) >>> FRAC_BITS;
        if (!pfinal_reg)
        begin
            res = AW'(rnd[SW-1:0]);
        end
        else if (rnd > EMAX)
        begin
            res = AW'(EMAX[ELEM_W-1:0]);
        end
        else if (rnd < EMIN)
        begin
            res = AW'(EMIN[ELEM_W-1:0]);
        end
        else
        begin
            res = AW'(rnd[ELEM_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < 9; e++)
            begin
                m_reg[e] <= (e % 4 == 0) ? ONE_M : '0;
            end
            px_reg        <= '0;
            py_reg        <= '0;
            pz_reg        <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= cmd.mac_issue;
            if (cmd.reset_state)
            begin
                for (int e = 0; e < 9; e++)
                begin
                    m_reg[e] <= (e % 4 == 0) ? ONE_M : '0;
                end
                px_reg <= '0;
                py_reg <= '0;
                pz_reg <= '0;
            end
            else if (cmd.commit_m)
            begin
                for (int e = 0; e < 9; e++)
                begin
                    m_reg[e] <= n_reg[e][ELEM_W-1:0];
                end
                px_reg <= ax_reg;
                py_reg <= ay_reg;
                pz_reg <= az_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ax_reg <= angle_x;
            ay_reg <= angle_y;
            az_reg <= angle_z;
            dx_reg <= reduce360(angle_x, px_reg);
            dy_reg <= reduce360(angle_y, py_reg);
            dz_reg <= reduce360(angle_z, pz_reg);
        end
        if (cmd.init_t)
        begin
            for (int e = 0; e < 9; e++)
            begin
                t_reg[e] <= (e % 4 == 0) ? ONE_T : '0;
            end
        end
        else if (cmd.commit_t)
        begin
            for (int e = 0; e < 9; e++)
            begin
                t_reg[e] <= n_reg[e][SW-1:0];
            end
        end
        if (cmd.load_g)
        begin
            case (cmd.axis)
                AXIS_X:
                begin
                    g_reg <= '{ONE_T, '0, '0, '0, c_val, -s_val, '0, s_val, c_val};
                end
                AXIS_Y:
                begin
                    g_reg <= '{c_val, '0, s_val, '0, ONE_T, '0, -s_val, '0, c_val};
                end
                default:
                begin
                    g_reg <= '{c_val, -s_val, '0, s_val, c_val, '0, '0, '0, ONE_T};
                end
            endcase
        end
        prod_reg   <= a_op * b_op;
        pfirst_reg <= cmd.mac_first;
        plast_reg  <= cmd.mac_last;
        pfinal_reg <= cmd.mac_final;
        pidx_reg   <= e_idx;
        if (pv_reg)
        begin
            acc_reg <= sum;
            if (plast_reg)
            begin
                n_reg[pidx_reg] <= res;
            end
        end
        if (cmd.out_load)
        begin
            out_row_reg <= cmd.out_row;
            case (cmd.out_row)
                2'd0:
                begin
                    oe0_reg <= m_reg[0];
                    oe1_reg <= m_reg[3];
                    oe2_reg <= m_reg[6];
                end
                2'd1:
                begin
                    oe0_reg <= m_reg[1];
                    oe1_reg <= m_reg[4];
                    oe2_reg <= m_reg[7];
                end
                2'd2:
                begin
                    oe0_reg <= m_reg[2];
                    oe1_reg <= m_reg[5];
                    oe2_reg <= m_reg[8];
                end
                default:
                begin
                    oe0_reg <= '0;
                    oe1_reg <= '0;
                    oe2_reg <= '0;
                end
            endcase
        end
    end

    assign stat.nonzero  = {dz_reg != '0, dy_reg != '0, dx_reg != '0};
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_e0    = oe0_reg;
    assign out_e1    = oe1_reg;
    assign out_e2    = oe2_reg;
    assign out_e3    = (out_row_reg == 2'd3) ? ONE_M : '0;
    assign out_last  = (out_row_reg == 2'd3);

endmodule

`default_nettype wire

FILE: src/incremental_rotation_accumulator_top.sv
`default_nettype none

// Incremental rotation accumulator. Each input transaction carries absolute X, Y and Z
// angles in whole degrees (s_tdata) and an operation bit (s_tuser[0]: 0 rotates, 1
// resets). A rotate transaction takes the difference to the previously stored angles,
// reduces it to 0..359, builds R = Rz*Ry*Rx from an elaborated sine table and replaces
// the stored 3x3 matrix M with M*R, clamping each element to signed Q(18-FRAC_BITS).FRAC_BITS in
// 18 bits. It then sends four output transactions, the rows of the transposed 4x4
// matrix, with tlast on the fourth. A reset transaction restores identity and zero
// angles and sends nothing; the rotate transaction that follows it sends the identity
// and changes nothing. All products go through one shared multiplier with a registered
// product, three products per matrix element and nine elements per matrix product, so the
// time a rotate transaction takes after it is accepted, before the first row is loaded
// into the output register, grows with the number of axes with a nonzero delta. A reset
// transaction leaves the block idle. Input is taken only while the block is idle; a
// finished row waits in the output register.

module incremental_rotation_accumulator_top
    import ira_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata fields from bit 0: angle_x[9:0], angle_y[19:10], angle_z[29:20], zero pad.
    input  wire logic [31:0] s_tdata,
    // s_tuser fields from bit 0: operation.
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata fields from bit 0: row_index[1:0], elem_0[19:2], elem_1[37:20],
    // elem_2[55:38], elem_3[73:56], zero pad.
    output logic [79:0]      m_tdata,
    output logic             m_tlast
);

    cmd_t  cmd;
    stat_t stat;

    logic [1:0]               row;
    logic signed [ELEM_W-1:0] e0, e1, e2, e3;

    // The controller sequences every phase; the datapath holds all matrices and angles.
    ira_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser[0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ira_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .angle_x   (s_tdata[9:0]),
        .angle_y   (s_tdata[19:10]),
        .angle_z   (s_tdata[29:20]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (row),
        .out_e0    (e0),
        .out_e1    (e1),
        .out_e2    (e2),
        .out_e3    (e3),
        .out_last  (m_tlast)
    );

    assign m_tdata = {6'd0, e3, e2, e1, e0, row};

    // The block is ready again in the cycle after a reset transaction is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] == OP_RESET |=> s_tready)
        else $error("block busy after reset transaction");

    // A rotate transaction always takes the block out of idle once it is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] == OP_ROTATE |=> !s_tready)
        else $error("block idle right after rotate transaction");

    // Once the first row leaves, the remaining rows are still being handed out.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tdata[1:0] == 2'd0 |=> !s_tready)
        else $error("input accepted in the middle of a matrix");

    // tlast marks exactly the fourth row.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'd3)))
        else $error("tlast does not match row index");

endmodule

`default_nettype wire
